// ===== src/tws_pkg.sv =====
// shared types and constants of the tagged word stack alu
package tws_pkg;

    localparam logic [31:0] HEADER_MASK  = 32'hc000_0000;
    localparam logic [31:0] PAYLOAD_MASK = 32'h3fff_ffff;
    localparam int          HEADER_SHIFT = 30;

    localparam logic [1:0] HDR_PUSH     = 2'd0;
    localparam logic [1:0] HDR_PRIM_LO  = 2'd1;
    localparam logic [1:0] HDR_PUSH_NEG = 2'd2;
    localparam logic [1:0] HDR_PRIM_HI  = 2'd3;

    localparam logic [31:0] PRIM_HALT = 32'd0;
    localparam logic [31:0] PRIM_ADD  = 32'd1;
    localparam logic [31:0] PRIM_SUB  = 32'd2;
    localparam logic [31:0] PRIM_MUL  = 32'd3;
    localparam logic [31:0] PRIM_DIV  = 32'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_HALTED    = 3'd4;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_HALT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [31:0] value;
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DIV
    } back_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } div_state_t;

endpackage

// ===== src/tws_if.sv =====
// valid/ready channel interfaces for instruction words and results
interface tws_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink (input valid, input instruction_word, output ready);
endinterface

interface tws_out_if #(
    parameter int LEVEL_W = 9
);
    logic                  valid;
    logic                  ready;
    logic signed [31:0]    top_value;
    logic [LEVEL_W-1:0]    stack_level;
    logic                  is_halted;
    logic [2:0]            status;

    modport source (output valid, output top_value, output stack_level,
                    output is_halted, output status, input ready);
    modport sink (input valid, input top_value, input stack_level,
                  input is_halted, input status, output ready);
endinterface

// ===== src/tagged_word_stack_alu_top.sv =====
// top level of the tagged word stack alu
// The block executes one 32-bit instruction word per transaction and returns one result
// transaction per word: top of stack (0 when empty), depth, halted flag and status. A front
// end decodes each word into a two-entry operation queue, and a back end runs the operations
// one at a time against a stack memory of STACK_DEPTH words whose top entry is held in a
// register; the memory needs no clearing pass after reset. A word enters the queue whenever it
// is not full; in the back end a push, halt, unknown primitive, error or ignored word completes
// in the idle state, add, sub and mul go on to an execute state (after one registered memory
// read of the value below the top), and div then waits for the radix-2 divider that resolves one
// quotient bit per cycle. Results are held in an output register; the back end starts the next
// operation only once that register is free, while the front end keeps filling the queue.
module tagged_word_stack_alu_top #(
    parameter int STACK_DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    tws_in_if.sink    instr,
    tws_out_if.source result
);
    import tws_pkg::*;

    logic q_full;
    logic q_wr;
    op_t  q_wr_op;
    logic q_rd;
    logic q_valid;
    op_t  q_rd_op;

    tws_front u_front (
        .instr   (instr),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_wr_op (q_wr_op)
    );

    tws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_op    (q_wr_op),
        .full     (q_full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_op    (q_rd_op)
    );

    tws_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (q_rd_op),
        .q_pop   (q_rd),
        .result  (result)
    );

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (32'(result.stack_level) <= 32'(STACK_DEPTH)))
        else $error("stack level above depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_OVERFLOW)
            |-> (32'(result.stack_level) == 32'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    a_underflow_short: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_UNDERFLOW)
            |-> (32'(result.stack_level) < 32'd2))
        else $error("underflow reported with two or more values");

    a_ignored_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_HALTED) |-> result.is_halted)
        else $error("ignored transaction without halted flag");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.stack_level == '0) |-> (result.top_value == '0))
        else $error("empty stack reports nonzero top");
`endif

endmodule

// ===== src/tws_front.sv =====
// front end: accepts instruction words and decodes them into operations
module tws_front (
    tws_in_if.sink      instr,
    input  logic        q_full,
    output logic        q_wr,
    output tws_pkg::op_t q_wr_op
);
    import tws_pkg::*;

    logic [1:0]  header;
    logic [31:0] payload;

    assign header  = 2'((instr.instruction_word & HEADER_MASK) >> HEADER_SHIFT);
    assign payload = instr.instruction_word & PAYLOAD_MASK;

    assign instr.ready = !q_full;
    assign q_wr        = instr.valid && !q_full;

    always_comb
    begin
        q_wr_op.value = payload;
        q_wr_op.kind  = OP_NOP;
        unique case (header) inside
            HDR_PUSH:
            begin
                q_wr_op.kind = OP_PUSH;
            end
            HDR_PUSH_NEG:
            begin
                q_wr_op.kind  = OP_PUSH;
                q_wr_op.value = 32'd0 - payload;
            end
            HDR_PRIM_LO, HDR_PRIM_HI:
            begin
                unique case (payload)
                    PRIM_HALT: q_wr_op.kind = OP_HALT;
                    PRIM_ADD:  q_wr_op.kind = OP_ADD;
                    PRIM_SUB:  q_wr_op.kind = OP_SUB;
                    PRIM_MUL:  q_wr_op.kind = OP_MUL;
                    PRIM_DIV:  q_wr_op.kind = OP_DIV;
                    default:   q_wr_op.kind = OP_NOP;
                endcase
            end
            default:
            begin
                q_wr_op.kind = OP_NOP;
            end
        endcase
    end

endmodule

// ===== src/tws_queue.sv =====
// small operation queue between the front and back ends
module tws_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  tws_pkg::op_t wr_op,
    output logic         full,
    input  logic         rd,
    output logic         rd_valid,
    output tws_pkg::op_t rd_op
);
    import tws_pkg::*;

    op_t            ent_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, wptr_next;
    logic [QAW-1:0] rptr_reg, rptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCW'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_op    = ent_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wr ? wptr_reg + QAW'(1) : wptr_reg;
        rptr_next = rd ? rptr_reg + QAW'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            ent_reg[wptr_reg] <= wr_op;
        end
    end

endmodule

// ===== src/tws_div.sv =====
// radix-2 signed divider, truncating toward zero
module tws_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import tws_pkg::*;

    div_state_t  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign rem_sub  = rem_sh - {1'b0, dsr_reg};
    assign done     = (state_reg == DV_DONE);
    assign quotient = neg_reg ? 32'd0 - quo_reg : quo_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    quo_next   = dividend[31] ? 32'd0 - dividend : dividend;
                    dsr_next   = divisor[31] ? 32'd0 - divisor : divisor;
                    neg_next   = dividend[31] ^ divisor[31];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (!rem_sub[32])
                begin
                    rem_next = rem_sub[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== src/tws_back.sv =====
// back end: stack memory, top-of-stack register, alu sequencing and result register
module tws_back #(
    parameter int STACK_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  tws_pkg::op_t q_op,
    output logic         q_pop,
    tws_out_if.source    result
);
    import tws_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rd_data_reg;

    back_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   top_reg, top_next;
    logic          halted_reg, halted_next;
    op_kind_t      kind_reg, kind_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_top_reg, out_top_next;
    logic [CW-1:0] out_level_reg, out_level_next;
    logic          out_halted_reg, out_halted_next;
    logic [2:0]    out_status_reg, out_status_next;

    logic          out_free;
    logic          emit;
    logic [2:0]    emit_status;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic          div_start;
    logic          div_done;
    logic [31:0]   div_q;

    assign out_free  = !out_valid_reg || result.ready;
    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign mem_waddr = cnt_m1[AW-1:0];
    assign mem_raddr = cnt_m2[AW-1:0];

    assign result.valid       = out_valid_reg;
    assign result.top_value   = out_top_reg;
    assign result.stack_level = out_level_reg;
    assign result.is_halted   = out_halted_reg;
    assign result.status      = out_status_reg;

    tws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        halted_next     = halted_reg;
        kind_next       = kind_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        emit_status     = ST_OK;
        mem_we          = 1'b0;
        div_start       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    if (halted_reg)
                    begin
                        emit_status = ST_HALTED;
                    end
                    else
                    begin
                        unique case (q_op.kind) inside
                            OP_PUSH:
                            begin
                                if (count_reg == CW'(STACK_DEPTH))
                                begin
                                    emit_status = ST_OVERFLOW;
                                end
                                else
                                begin
                                    mem_we     = (count_reg != '0);
                                    top_next   = q_op.value;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                            OP_HALT:
                            begin
                                halted_next = 1'b1;
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                            begin
                                if (count_reg < CW'(2))
                                begin
                                    emit_status = ST_UNDERFLOW;
                                end
                                else if (q_op.kind == OP_DIV && top_reg == '0)
                                begin
                                    emit_status = ST_DIVZERO;
                                end
                                else
                                begin
                                    emit       = 1'b0;
                                    kind_next  = q_op.kind;
                                    state_next = BK_EXEC;
                                end
                            end
                            default:
                            begin
                                emit_status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            BK_EXEC:
            begin
                unique case (kind_reg)
                    OP_ADD:
                    begin
                        top_next   = rd_data_reg + top_reg;
                        count_next = cnt_m1;
                        emit       = 1'b1;
                        state_next = BK_IDLE;
                    end
                    OP_SUB:
                    begin
                        top_next   = rd_data_reg - top_reg;
                        count_next = cnt_m1;
                        emit       = 1'b1;
                        state_next = BK_IDLE;
                    end
                    OP_MUL:
                    begin
                        top_next   = rd_data_reg * top_reg;
                        count_next = cnt_m1;
                        emit       = 1'b1;
                        state_next = BK_IDLE;
                    end
                    default:
                    begin
                        div_start  = 1'b1;
                        state_next = BK_DIV;
                    end
                endcase
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    top_next   = div_q;
                    count_next = cnt_m1;
                    emit       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_top_next    = out_top_reg;
        out_level_next  = out_level_reg;
        out_halted_next = out_halted_reg;
        out_status_next = out_status_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_top_next    = (count_next == '0) ? '0 : top_next;
            out_level_next  = count_next;
            out_halted_next = halted_next;
            out_status_next = emit_status;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        kind_reg       <= kind_next;
        out_top_reg    <= out_top_next;
        out_level_reg  <= out_level_next;
        out_halted_reg <= out_halted_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= top_reg;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

// ===== tb/sv/tagged_word_stack_alu_checker.sv =====
`timescale 1ns / 1ps
// watches the instruction and result channels, predicts each result and compares it
module tagged_word_stack_alu_checker #(
    parameter int STACK_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    tws_in_if    instr,
    tws_out_if   result,
    output int   mismatches,
    output int   outstanding
);
    import tws_pkg::*;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [8:0]         stack_level;
        logic               is_halted;
        logic [2:0]         status;
    } step_result_t;

    logic [31:0]  stack_mem [STACK_DEPTH];
    int unsigned  depth;
    logic         halted;
    step_result_t awaited_results [$];

    function automatic logic [31:0] quotient_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] q;
        mag_a = a[31] ? 32'd0 - a : a;
        mag_b = b[31] ? 32'd0 - b : b;
        q = mag_a / mag_b;
        return (a[31] ^ b[31]) ? 32'd0 - q : q;
    endfunction

    function automatic logic [2:0] push_value(input logic [31:0] value);
        if (depth >= STACK_DEPTH)
        begin
            return ST_OVERFLOW;
        end
        stack_mem[depth] = value;
        depth++;
        return ST_OK;
    endfunction

    function automatic logic [2:0] run_primitive(input logic [31:0] code);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        if (code == PRIM_HALT)
        begin
            halted = 1'b1;
            return ST_OK;
        end
        if (code > PRIM_DIV)
        begin
            return ST_OK;
        end
        if (depth < 2)
        begin
            return ST_UNDERFLOW;
        end
        a = stack_mem[depth - 2];
        b = stack_mem[depth - 1];
        case (code)
            PRIM_ADD: r = a + b;
            PRIM_SUB: r = a - b;
            PRIM_MUL: r = a * b;
            default:
            begin
                if (b == 32'd0)
                begin
                    return ST_DIVZERO;
                end
                r = quotient_trunc(a, b);
            end
        endcase
        stack_mem[depth - 2] = r;
        depth--;
        return ST_OK;
    endfunction

    function automatic step_result_t execute_word(input logic [31:0] word);
        step_result_t res;
        logic [1:0]   hdr;
        logic [31:0]  payload;
        hdr = 2'((word & HEADER_MASK) >> HEADER_SHIFT);
        payload = word & PAYLOAD_MASK;
        if (halted)
        begin
            res.status = ST_HALTED;
        end
        else if (hdr == HDR_PUSH)
        begin
            res.status = push_value(payload);
        end
        else if (hdr == HDR_PUSH_NEG)
        begin
            res.status = push_value(32'd0 - payload);
        end
        else
        begin
            res.status = run_primitive(payload);
        end
        res.top_value = (depth > 0) ? stack_mem[depth - 1] : 32'd0;
        res.stack_level = 9'(depth);
        res.is_halted = halted;
        return res;
    endfunction

    always @(posedge clk)
    begin
        step_result_t got;
        step_result_t want;
        if (!rst_n)
        begin
            depth = 0;
            halted = 1'b0;
            awaited_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.top_value = result.top_value;
                got.stack_level = result.stack_level;
                got.is_halted = result.is_halted;
                got.status = result.status;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: unexpected result transaction top %0d level %0d",
                                 got.top_value, got.stack_level);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.top_value !== want.top_value || got.stack_level !== want.stack_level
                        || got.is_halted !== want.is_halted || got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch: top %0d/%0d level %0d/%0d", want.top_value,
                                   got.top_value, want.stack_level, got.stack_level);
                            $display(" halted %0b/%0b status %0d/%0d (expected/actual)",
                                     want.is_halted, got.is_halted, want.status, got.status);
                        end
                    end
                end
            end
            if (instr.valid && instr.ready)
            begin
                awaited_results.push_back(execute_word(instr.instruction_word));
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

// ===== tb/sv/tagged_word_stack_alu_top_tb.sv =====
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the tagged word stack alu
module tagged_word_stack_alu_top_tb;
    import tws_pkg::*;

    localparam int          DEPTH              = 256;
    localparam int          CYCLE_LIMIT        = 200000;
    localparam logic [31:0] PRIM_FIRST_UNKNOWN = PRIM_DIV + 1;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   cycles = 0;
    int   mismatches;
    int   outstanding;

    tws_in_if  instr ();
    tws_out_if result ();

    tagged_word_stack_alu_top #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .instr (instr),
        .result(result)
    );

    tagged_word_stack_alu_checker #(
        .STACK_DEPTH(DEPTH)
    ) step_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr      (instr),
        .result     (result),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result.ready <= rst_n && (no_idle || $urandom_range(99) >= 38);
    end

    function automatic logic [31:0] make_word(input logic [1:0] hdr, input logic [31:0] payload);
        return {hdr, payload[29:0]};
    endfunction

    function automatic logic [31:0] random_push();
        logic [31:0] operand;
        case ($urandom_range(7)) inside
            0:       operand = '0;
            1, 2:    operand = $urandom_range(9, 1);
            default: operand = $urandom();
        endcase
        return make_word($urandom_range(1) ? HDR_PUSH_NEG : HDR_PUSH, operand);
    endfunction

    task automatic send_word(input logic [31:0] word);
        while (!no_idle && $urandom_range(99) < 38)
        begin
            instr.valid <= 1'b0;
            @(negedge clk);
        end
        instr.valid <= 1'b1;
        instr.instruction_word <= word;
        @(posedge clk);
        while (!instr.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_item(input int push_pct, input int noise_pct);
        int         pick;
        logic [1:0] hdr;
        pick = $urandom_range(99);
        hdr = $urandom_range(1) ? HDR_PRIM_HI : HDR_PRIM_LO;
        if (pick < push_pct)
            send_word(random_push());
        else if (pick < push_pct + noise_pct)
            send_word(make_word(hdr, $urandom_range(PAYLOAD_MASK, PRIM_FIRST_UNKNOWN)));
        else
            send_word(make_word(hdr, $urandom_range(PRIM_DIV, PRIM_ADD)));
    endtask

    task automatic drain_results();
        instr.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] directed_words [$];
        rst_n = 1'b0;
        no_idle = 1'b0;
        instr.valid = 1'b0;
        instr.instruction_word = '0;
        result.ready = 1'b0;
        directed_words = '{
            make_word(HDR_PRIM_LO, PRIM_ADD),
            make_word(HDR_PUSH, 32'd0),
            make_word(HDR_PRIM_HI, PRIM_SUB),
            make_word(HDR_PUSH, PAYLOAD_MASK),
            make_word(HDR_PUSH_NEG, PAYLOAD_MASK),
            make_word(HDR_PRIM_LO, PRIM_ADD),
            make_word(HDR_PUSH_NEG, 32'd0),
            make_word(HDR_PRIM_HI, PRIM_DIV),
            make_word(HDR_PRIM_LO, PRIM_FIRST_UNKNOWN),
            make_word(HDR_PRIM_HI, PAYLOAD_MASK),
            make_word(HDR_PUSH, 32'h2000_0000),
            make_word(HDR_PUSH, 32'd4),
            make_word(HDR_PRIM_LO, PRIM_MUL),
            make_word(HDR_PUSH_NEG, 32'd1),
            make_word(HDR_PRIM_HI, PRIM_DIV),
            make_word(HDR_PUSH_NEG, 32'd7),
            make_word(HDR_PRIM_LO, PRIM_DIV),
            make_word(HDR_PUSH, 32'd3),
            make_word(HDR_PRIM_HI, PRIM_SUB),
            make_word(HDR_PUSH_NEG, 32'h1555_5555),
            make_word(HDR_PRIM_LO, PRIM_MUL),
            make_word(HDR_PUSH, 32'd5),
            make_word(HDR_PRIM_HI, PRIM_DIV),
            make_word(HDR_PUSH_NEG, 32'h2aaa_aaaa),
            make_word(HDR_PRIM_LO, PRIM_ADD)
        };
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_words[i])
            send_word(directed_words[i]);
        drain_results();

        // fill past capacity with both sides running flat out
        no_idle = 1'b1;
        repeat (262) send_word(random_push());
        no_idle = 1'b0;

        // mostly arithmetic, walks the stack back down
        repeat (90) send_random_item(8, 4);
        repeat (20) send_random_item(45, 8);

        // halt, then everything after it is ignored
        send_word(make_word(HDR_PRIM_HI, PRIM_HALT));
        send_word(make_word(HDR_PRIM_LO, PRIM_HALT));
        repeat (6) send_word($urandom());
        send_word(random_push());
        send_word(make_word(HDR_PRIM_LO, PRIM_ADD));
        drain_results();
        repeat (40) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tws_pkg.sv
src/tws_if.sv
src/tws_front.sv
src/tws_queue.sv
src/tws_div.sv
src/tws_back.sv
src/tagged_word_stack_alu_top.sv
tb/sv/tagged_word_stack_alu_checker.sv
tb/sv/tagged_word_stack_alu_top_tb.sv
